// ----- hw/rtl/clt_pkg.sv -----
// Package for the compacting list table: transfer item types, opcode and status codes,
// and the control store of the microcoded sequencer.
// Self-contained; imported by every module of the block.
package clt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] index;
        logic [4:0] count;
    } t_out_item;

    // Jump conditions.
    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_GOTO     = 3'd1;
    localparam logic [2:0] JC_DISPATCH = 3'd2;
    localparam logic [2:0] JC_IF_FULL  = 3'd3;
    localparam logic [2:0] JC_IF_MISS  = 3'd4;

    // Index sources for a report.
    localparam logic [1:0] IDX_ZERO  = 2'd0;
    localparam logic [1:0] IDX_COUNT = 2'd1;
    localparam logic [1:0] IDX_HIT   = 2'd2;

    localparam int unsigned STEP_W = 4;

    // Step addresses of the microprogram.
    localparam logic [STEP_W-1:0] A_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] A_INS      = 4'd1;
    localparam logic [STEP_W-1:0] A_INS_DO   = 4'd2;
    localparam logic [STEP_W-1:0] A_INS_FULL = 4'd3;
    localparam logic [STEP_W-1:0] A_FIND     = 4'd4;
    localparam logic [STEP_W-1:0] A_FIND_CHK = 4'd5;
    localparam logic [STEP_W-1:0] A_FIND_HIT = 4'd6;
    localparam logic [STEP_W-1:0] A_DEL      = 4'd7;
    localparam logic [STEP_W-1:0] A_DEL_CHK  = 4'd8;
    localparam logic [STEP_W-1:0] A_DEL_DO   = 4'd9;
    localparam logic [STEP_W-1:0] A_NOP      = 4'd10;
    localparam logic [STEP_W-1:0] A_MISS     = 4'd11;

    typedef struct packed {
        logic [2:0]        jump;
        logic [STEP_W-1:0] target;
        logic              act_insert;
        logic              act_compare;
        logic              act_delete;
        logic              report;
        logic [1:0]        status;
        logic [1:0]        idx_sel;
    } t_ctrl;

    typedef struct packed {
        logic full;
        logic miss;
    } t_flags;

    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] addr);
        t_ctrl w;
        w = '{jump: JC_GOTO, target: A_IDLE, act_insert: 1'b0, act_compare: 1'b0,
              act_delete: 1'b0, report: 1'b0, status: ST_DONE, idx_sel: IDX_ZERO};
        case (addr)
            A_IDLE: begin
                w.jump = JC_DISPATCH;
            end
            A_INS: begin
                w.jump   = JC_IF_FULL;
                w.target = A_INS_FULL;
            end
            A_INS_DO: begin
                w.act_insert = 1'b1;
                w.report     = 1'b1;
                w.idx_sel    = IDX_COUNT;
            end
            A_INS_FULL: begin
                w.report = 1'b1;
                w.status = ST_FULL;
            end
            A_FIND: begin
                w.jump        = JC_NEXT;
                w.act_compare = 1'b1;
            end
            A_FIND_CHK: begin
                w.jump   = JC_IF_MISS;
                w.target = A_MISS;
            end
            A_FIND_HIT: begin
                w.report  = 1'b1;
                w.idx_sel = IDX_HIT;
            end
            A_DEL: begin
                w.jump        = JC_NEXT;
                w.act_compare = 1'b1;
            end
            A_DEL_CHK: begin
                w.jump   = JC_IF_MISS;
                w.target = A_MISS;
            end
            A_DEL_DO: begin
                w.act_delete = 1'b1;
                w.report     = 1'b1;
                w.idx_sel    = IDX_HIT;
            end
            A_NOP: begin
                w.report = 1'b1;
            end
            A_MISS: begin
                w.report = 1'b1;
                w.status = ST_MISSING;
            end
            default: begin
                w.jump = JC_GOTO;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/clt_seq.sv -----
// Microcoded sequencer of the compacting list table: step counter, control store
// lookup and jump logic. Depends on clt_pkg.
module clt_seq
    import clt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_opcode,
    input  t_flags     i_flags,
    output t_ctrl      o_ctrl,
    output logic       o_busy
);

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    logic [STEP_W-1:0] entry;
    t_ctrl             ctrl;

    assign ctrl   = rom_word(r_pc);
    assign o_ctrl = ctrl;
    assign o_busy = (r_pc != A_IDLE);

    always_comb begin
        case (i_opcode)
            OP_INSERT: entry = A_INS;
            OP_FIND:   entry = A_FIND;
            OP_DELETE: entry = A_DEL;
            default:   entry = A_NOP;
        endcase
    end

    always_comb begin
        case (ctrl.jump)
            JC_NEXT:     n_pc = r_pc + 1'b1;
            JC_GOTO:     n_pc = ctrl.target;
            JC_DISPATCH: n_pc = i_start ? entry : r_pc;
            JC_IF_FULL:  n_pc = i_flags.full ? ctrl.target : r_pc + 1'b1;
            JC_IF_MISS:  n_pc = i_flags.miss ? ctrl.target : r_pc + 1'b1;
            default:     n_pc = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Leaving idle only happens through a dispatch on start.
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == A_IDLE && !i_start) |=> (r_pc == A_IDLE))
        else $error("sequencer left idle without start");

endmodule

// ----- hw/rtl/clt_cells.sv -----
// Datapath of the compacting list table: the row of list cells, the valid count,
// the parallel compare with first-match pick, the one-step shift and the result register.
// Depends on clt_pkg; driven by clt_seq control words.
module clt_cells
    import clt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  logic signed [31:0] i_value,
    output t_flags             o_flags,
    output logic               o_strobe,
    output t_out_item          o_result
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [31:0] r_cells [CAPACITY];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [CAPACITY-1:0] match;
    logic               any_match;
    logic [IDX_W-1:0]   first_idx;
    logic               full;
    logic               do_insert;
    logic               do_delete;
    logic [IDX_W-1:0]   rpt_idx;
    logic               r_strobe;
    t_out_item          r_result;

    assign full      = (r_count == COUNT_W'(CAPACITY));
    assign do_insert = i_ctrl.act_insert && !full;
    assign do_delete = i_ctrl.act_delete && r_hit;

    assign o_flags.full = full;
    assign o_flags.miss = !r_hit;

    // Only cells below the valid count take part in the search.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (r_cells[i] == i_value) && (COUNT_W'(i) < r_count);
        end
    end

    assign any_match = |match;

    always_comb begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + 1'b1;
        end else if (do_delete) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        case (i_ctrl.idx_sel)
            IDX_COUNT: rpt_idx = IDX_W'(r_count);
            IDX_HIT:   rpt_idx = r_hit_idx;
            default:   rpt_idx = '0;
        endcase
    end

    // Delete moves every later valid cell down one place in a single step.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (do_insert && (r_count == COUNT_W'(i))) begin
                r_cells[i] <= i_value;
            end else if (do_delete && (COUNT_W'(i) >= COUNT_W'(r_hit_idx))
                         && (COUNT_W'(i + 1) < r_count)) begin
                r_cells[i] <= r_cells[(i + 1) % CAPACITY];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hit    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_ctrl.report;
            if (i_ctrl.act_compare) begin
                r_hit <= any_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.act_compare) begin
            r_hit_idx <= first_idx;
        end
        if (i_ctrl.report) begin
            r_result.status <= i_ctrl.status;
            r_result.index  <= 4'(rpt_idx);
            r_result.count  <= 5'(n_count);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("valid count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_delete |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not shrink the list");

endmodule

// ----- hw/rtl/compacting_list_table_unit.sv -----
// Compacting list table, top level: operand capture and wiring of the microcoded
// sequencer to the cell datapath. Depends on clt_pkg.
// One control store step per cycle; insert checks for a full list before its report, find and
// delete compare and check for a miss first. A new command is taken while the result is shown;
// results last one cycle and the receiver cannot stall them. Reset idles the sequencer and
// clears the count, the hit flag and the strobe, but not the cells or the result.
module compacting_list_table_unit
    import clt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic               accept;
    logic signed [31:0] r_value;
    t_ctrl              ctrl;
    t_flags             flags;

    assign accept = start && !busy;

    // The operand is held for the compare and write steps.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= i_item.value;
        end
    end

    clt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_flags  (flags),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    clt_cells #(
        .CAPACITY (CAPACITY)
    ) u_cells (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_value  (r_value),
        .o_flags  (flags),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command accepted but sequencer not busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while sequencer still busy");

endmodule

// ----- test/tb_compacting_list_table_unit.sv -----
// Testbench for compacting_list_table_unit: drives insert, find, delete and unused-opcode commands
// and checks every result against a predictor of the list contents and count.
// Depends on clt_pkg and the compacting_list_table_unit RTL.
module tb_compacting_list_table_unit;
    import clt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1520;
    localparam int QUIET_TAIL   = 200;
    localparam int POOL_SIZE    = 8;
    localparam int POOL_REFRESH = 160;
    localparam int PHASE_LEN    = 40;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    t_in_item  command_queue[$];
    t_out_item expected_results[$];

    logic signed [31:0] table_cells[CAPACITY];
    int table_count    = 0;
    int sent_count     = 0;
    int total_items    = 0;
    int idle_left      = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    compacting_list_table_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one command to the shadow list and returns the result it must produce.
    function automatic t_out_item apply_table_command(input t_in_item cmd);
        t_out_item r;
        int hit;
        r.status = ST_DONE;
        r.index  = '0;
        hit      = -1;
        for (int i = 0; i < table_count; i++) begin
            if (hit < 0 && table_cells[i] == cmd.value) hit = i;
        end
        case (cmd.opcode)
            OP_INSERT: begin
                if (table_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    r.index = table_count[3:0];
                    table_cells[table_count] = cmd.value;
                    table_count++;
                end
            end
            OP_FIND: begin
                if (hit < 0) r.status = ST_MISSING;
                else r.index = hit[3:0];
            end
            OP_DELETE: begin
                if (hit < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    r.index = hit[3:0];
                    for (int i = hit; i + 1 < table_count; i++)
                        table_cells[i] = table_cells[i + 1];
                    table_count--;
                end
            end
            default: begin
            end
        endcase
        r.count = table_count[4:0];
        return r;
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [31:0] val);
        t_in_item cmd;
        cmd.opcode = op;
        cmd.value  = val;
        command_queue.push_back(cmd);
    endtask

    task automatic note_mismatch(input bit has_want, input t_out_item want,
                                 input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (has_want) begin
                $display("result mismatch: expected status %0d index %0d count %0d",
                         want.status, want.index, want.count);
                $display("    got status %0d index %0d count %0d",
                         got.status, got.index, got.count);
            end else begin
                $display("result with no command pending: status %0d index %0d count %0d",
                         got.status, got.index, got.count);
            end
        end
    endtask

    // Driver: holds each command until the transfer, then may idle for a short burst.
    always @(posedge i_clk) begin
        logic     next_start;
        t_in_item next_item;
        next_start = start;
        next_item  = i_item;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(apply_table_command(i_item));
                sent_count++;
                next_start = 1'b0;
                if (sent_count < total_items - QUIET_TAIL && ((sent_count / 100) % 3) != 2
                        && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 6);
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (command_queue.size() > 0) begin
                    next_item  = command_queue.pop_front();
                    next_start = 1'b1;
                end
            end
        end
        start  <= next_start;
        i_item <= next_item;
    end

    // Monitor: every strobed result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                note_mismatch(1'b0, '0, o_result);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status || o_result.index !== want.index
                        || o_result.count !== want.count)
                    note_mismatch(1'b1, want, o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] value_pool[POOL_SIZE];
        int          insert_weight;
        int          pick;
        logic [1:0]  op;
        logic [31:0] val;

        // Empty list, unused opcode, extreme values and duplicates.
        push_cmd(OP_FIND, 32'h0000_0000);
        push_cmd(OP_DELETE, 32'h0000_0005);
        push_cmd(OP_UNUSED, $urandom);
        push_cmd(OP_INSERT, 32'h8000_0000);
        push_cmd(OP_INSERT, 32'h7FFF_FFFF);
        push_cmd(OP_INSERT, 32'h0000_0000);
        push_cmd(OP_INSERT, 32'hFFFF_FFFF);
        push_cmd(OP_INSERT, 32'h7FFF_FFFF);
        push_cmd(OP_FIND, 32'h7FFF_FFFF);
        push_cmd(OP_FIND, 32'hFFFF_FFFF);
        push_cmd(OP_DELETE, 32'h7FFF_FFFF);
        push_cmd(OP_FIND, 32'h7FFF_FFFF);
        push_cmd(OP_DELETE, 32'h8000_0000);
        // Fill to capacity, then insert once more into the full list.
        for (int k = 0; k < 14; k++) push_cmd(OP_INSERT, 32'(k * 7 + 10));
        push_cmd(OP_DELETE, 32'(12 * 7 + 10));
        push_cmd(OP_FIND, 32'(12 * 7 + 10));

        // Phases alternate between filling and draining so the list swings between
        // empty and full; most values come from a small pool so searches hit.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % POOL_REFRESH == 0) begin
                for (int k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom;
                value_pool[0] = ((n / POOL_REFRESH) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            insert_weight = ((n / PHASE_LEN) % 2) ? 20 : 70;
            pick = $urandom_range(0, 99);
            if (pick < 4) op = OP_UNUSED;
            else if (pick < 4 + insert_weight) op = OP_INSERT;
            else if ($urandom_range(0, 2) == 0) op = OP_FIND;
            else op = OP_DELETE;
            if ($urandom_range(0, 4) == 0) val = $urandom;
            else val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            push_cmd(op, val);
        end
        total_items = command_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (command_queue.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- compacting_list_table_unit.f -----
hw/rtl/clt_pkg.sv
hw/rtl/clt_seq.sv
hw/rtl/clt_cells.sv
hw/rtl/compacting_list_table_unit.sv
test/tb_compacting_list_table_unit.sv
